/* hw/rtl/blmo_pkg.sv */
package blmo_pkg;

    localparam int MAX_BOXES = 64;
    localparam int IDX_W     = $clog2(MAX_BOXES);
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);
    localparam int COORD_W   = 12;
    localparam int LABEL_W   = 7;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int OWN_W     = 2 * COORD_W;
    localparam int OVL_W     = 2 * EDGE_W;
    localparam int CMP_W     = OVL_W + 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_LABEL_REPLACE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LABEL_TARGET  = 1'd1;

    localparam logic [LABEL_W-1:0] LABEL_REPLACE_RST = 7'd7;
    localparam logic [LABEL_W-1:0] LABEL_TARGET_RST  = 7'd2;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic [LABEL_W-1:0] label;
    } box_t;

    localparam int BOX_W = $bits(box_t);

    typedef struct packed {
        logic busy;
        logic hit;
    } ovl_stat_t;

endpackage

/* hw/rtl/blmo_if.sv */
interface blmo_box_if;
    logic                             valid;
    logic                             ready;
    logic [blmo_pkg::COORD_W-1:0]     box_x;
    logic [blmo_pkg::COORD_W-1:0]     box_y;
    logic [blmo_pkg::COORD_W-1:0]     box_w;
    logic [blmo_pkg::COORD_W-1:0]     box_h;
    logic [blmo_pkg::LABEL_W-1:0]     box_label;
    logic                             last_box;

    modport source (output valid, box_x, box_y, box_w, box_h, box_label, last_box,
                    input ready);
    modport sink (input valid, box_x, box_y, box_w, box_h, box_label, last_box,
                  output ready);
endinterface

interface blmo_res_if;
    logic                             valid;
    logic                             ready;
    logic [blmo_pkg::IDX_W-1:0]       box_index;
    logic                             kept;
    logic [blmo_pkg::LABEL_W-1:0]     new_label;
    logic                             last_result;

    modport source (output valid, box_index, kept, new_label, last_result,
                    input ready);
    modport sink (input valid, box_index, kept, new_label, last_result,
                  output ready);
endinterface

/* hw/rtl/blmo_ram.sv */
module blmo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/blmo_ovl.sv */
module blmo_ovl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    input  blmo_pkg::box_t      box_a,
    input  blmo_pkg::box_t      box_b,
    output blmo_pkg::ovl_stat_t stat
);

    logic [blmo_pkg::EDGE_W-1:0] a_xe, b_xe, a_ye, b_ye;
    logic [blmo_pkg::EDGE_W-1:0] x1, x2, y1, y2;
    logic [blmo_pkg::EDGE_W-1:0] dx_reg, dy_reg;
    logic                        pos1_reg, pos2_reg, v1_reg, v2_reg;
    logic [blmo_pkg::OVL_W-1:0]  so_reg;
    logic [blmo_pkg::OWN_W-1:0]  own_reg;
    logic [blmo_pkg::CMP_W-1:0]  lhs, rhs;

    // Stage one: intersection edges of the two boxes.
    always_comb
    begin
        a_xe = {1'b0, box_a.x} + {1'b0, box_a.w};
        b_xe = {1'b0, box_b.x} + {1'b0, box_b.w};
        a_ye = {1'b0, box_a.y} + {1'b0, box_a.h};
        b_ye = {1'b0, box_b.y} + {1'b0, box_b.h};
        x2   = (a_xe < b_xe) ? a_xe : b_xe;
        y2   = (a_ye < b_ye) ? a_ye : b_ye;
        x1   = (box_a.x > box_b.x) ? {1'b0, box_a.x} : {1'b0, box_b.x};
        y1   = (box_a.y > box_b.y) ? {1'b0, box_a.y} : {1'b0, box_b.y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= x2 - x1;
        dy_reg   <= y2 - y1;
        pos1_reg <= (x2 > x1) && (y2 > y1);
        so_reg   <= dx_reg * dy_reg;
        own_reg  <= box_a.w * box_a.h;
        pos2_reg <= pos1_reg;
    end

    // 2*own < 3*overlap, exact in integers.
    assign lhs = {3'b000, own_reg, 1'b0};
    assign rhs = {2'b00, so_reg} + {1'b0, so_reg, 1'b0};

    assign stat.busy = v1_reg | v2_reg;
    assign stat.hit  = v2_reg && pos2_reg && (lhs < rhs);

endmodule

/* hw/rtl/box_label_merge_by_overlap_core.sv */
// Channel   Dir  Beat                                          Handshake
// boxes     in   box_x, box_y, box_w, box_h, box_label, last   valid/ready
// results   out  box_index, kept, new_label, last_result       valid/ready
// wr_*      in   wr_index, wr_data                             wr_en, no wait
//
// A box is stored as it is accepted; the frame ends on last_box or on the 64th box.
// A prep pass then classifies the stored labels; the walk skips each box that is
// not a kept replace box and checks each replace box through one overlap unit fed
// from the single read port of the box memory; each result is read, then offered.
// boxes is not ready from the end of a frame until its last result is taken.
// Reset is asynchronous and active low; the box memory needs no clearing.
module box_label_merge_by_overlap_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [blmo_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [blmo_pkg::LABEL_W-1:0]       wr_data,
    blmo_box_if.sink                           boxes,
    blmo_res_if.source                         results
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_PREP,
        S_WALK,
        S_RDI,
        S_INNER,
        S_UPDATE,
        S_OUT_RD,
        S_OUT_CAP,
        S_OUT_WAIT
    } state_t;

    localparam logic [blmo_pkg::CNT_W-1:0] CNT_FULL = blmo_pkg::CNT_W'(blmo_pkg::MAX_BOXES);

    state_t                           state_reg;
    logic [blmo_pkg::LABEL_W-1:0]     label_replace_reg, label_target_reg;
    logic [blmo_pkg::CNT_W-1:0]       cnt_reg, n_reg, i_reg, m_reg;
    logic [blmo_pkg::MAX_BOXES-1:0]   kept_reg, relab_reg, tgt_reg, rep_reg;
    logic                             prv_reg, rdv_reg, found_reg;
    logic [blmo_pkg::IDX_W-1:0]       pidx_reg;
    blmo_pkg::box_t                   bi_reg;
    logic                             out_valid_reg, out_kept_reg, out_last_reg;
    logic [blmo_pkg::IDX_W-1:0]       out_index_reg;
    logic [blmo_pkg::LABEL_W-1:0]     out_label_reg;

    logic                             accept;
    logic [blmo_pkg::CNT_W-1:0]       cnt_next;
    logic [blmo_pkg::IDX_W-1:0]       i_idx, m_idx, cnt_idx, raddr;
    blmo_pkg::box_t                   wbox, rbox;
    logic [blmo_pkg::BOX_W-1:0]       rdata;
    blmo_pkg::ovl_stat_t              ovl_stat;

    assign accept   = boxes.valid && boxes.ready;
    assign cnt_next = cnt_reg + 1'b1;
    assign i_idx    = i_reg[blmo_pkg::IDX_W-1:0];
    assign m_idx    = m_reg[blmo_pkg::IDX_W-1:0];
    assign cnt_idx  = cnt_reg[blmo_pkg::IDX_W-1:0];
    assign raddr    = (state_reg == S_WALK) ? i_idx : m_idx;
    assign rbox     = blmo_pkg::box_t'(rdata);

    always_comb
    begin
        wbox.x     = boxes.box_x;
        wbox.y     = boxes.box_y;
        wbox.w     = boxes.box_w;
        wbox.h     = boxes.box_h;
        wbox.label = boxes.box_label;
    end

    blmo_ram #(
        .WIDTH (blmo_pkg::BOX_W),
        .DEPTH (blmo_pkg::MAX_BOXES)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (cnt_idx),
        .wdata (wbox),
        .raddr (raddr),
        .rdata (rdata)
    );

    blmo_ovl u_ovl (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (rdv_reg),
        .box_a (bi_reg),
        .box_b (rbox),
        .stat  (ovl_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_replace_reg <= blmo_pkg::LABEL_REPLACE_RST;
            label_target_reg  <= blmo_pkg::LABEL_TARGET_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                blmo_pkg::REG_LABEL_REPLACE: label_replace_reg <= wr_data;
                blmo_pkg::REG_LABEL_TARGET:  label_target_reg  <= wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            m_reg         <= '0;
            kept_reg      <= '1;
            relab_reg     <= '0;
            tgt_reg       <= '0;
            rep_reg       <= '0;
            prv_reg       <= 1'b0;
            pidx_reg      <= '0;
            bi_reg        <= '0;
            rdv_reg       <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_kept_reg  <= 1'b0;
            out_label_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        kept_reg[cnt_idx]  <= 1'b1;
                        relab_reg[cnt_idx] <= 1'b0;
                        cnt_reg            <= cnt_next;
                        if (boxes.last_box || (cnt_next == CNT_FULL))
                        begin
                            n_reg     <= cnt_next;
                            m_reg     <= '0;
                            prv_reg   <= 1'b0;
                            state_reg <= S_PREP;
                        end
                    end
                end
                S_PREP:
                begin
                    // Read data arrives in the cycle after its address.
                    if (prv_reg)
                    begin
                        tgt_reg[pidx_reg] <= (rbox.label == label_target_reg);
                        rep_reg[pidx_reg] <= (rbox.label == label_replace_reg);
                    end
                    if (m_reg < n_reg)
                    begin
                        prv_reg  <= 1'b1;
                        pidx_reg <= m_idx;
                        m_reg    <= m_reg + 1'b1;
                    end
                    else
                    begin
                        prv_reg <= 1'b0;
                        if (!prv_reg)
                        begin
                            i_reg     <= '0;
                            state_reg <= S_WALK;
                        end
                    end
                end
                S_WALK:
                begin
                    if (i_reg == n_reg)
                    begin
                        m_reg     <= '0;
                        state_reg <= S_OUT_RD;
                    end
                    else if (kept_reg[i_idx] && rep_reg[i_idx])
                    begin
                        state_reg <= S_RDI;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_RDI:
                begin
                    bi_reg    <= rbox;
                    found_reg <= 1'b0;
                    m_reg     <= '0;
                    rdv_reg   <= 1'b0;
                    state_reg <= S_INNER;
                end
                S_INNER:
                begin
                    found_reg <= found_reg | ovl_stat.hit;
                    if (m_reg < n_reg)
                    begin
                        rdv_reg <= kept_reg[m_idx] && tgt_reg[m_idx];
                        m_reg   <= m_reg + 1'b1;
                    end
                    else
                    begin
                        rdv_reg <= 1'b0;
                        if (!rdv_reg && !ovl_stat.busy)
                        begin
                            state_reg <= S_UPDATE;
                        end
                    end
                end
                S_UPDATE:
                begin
                    if (found_reg)
                    begin
                        kept_reg[i_idx] <= 1'b0;
                    end
                    else
                    begin
                        relab_reg[i_idx] <= 1'b1;
                        tgt_reg[i_idx]   <= 1'b1;
                    end
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= S_WALK;
                end
                S_OUT_RD:
                begin
                    state_reg <= S_OUT_CAP;
                end
                S_OUT_CAP:
                begin
                    out_valid_reg <= 1'b1;
                    out_index_reg <= m_idx;
                    out_kept_reg  <= kept_reg[m_idx];
                    out_label_reg <= relab_reg[m_idx] ? label_target_reg : rbox.label;
                    out_last_reg  <= ((m_reg + 1'b1) == n_reg);
                    state_reg     <= S_OUT_WAIT;
                end
                S_OUT_WAIT:
                begin
                    if (results.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            cnt_reg   <= '0;
                            kept_reg  <= '1;
                            relab_reg <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            m_reg     <= m_reg + 1'b1;
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign boxes.ready         = (state_reg == S_LOAD);
    assign results.valid       = out_valid_reg;
    assign results.box_index   = out_index_reg;
    assign results.kept        = out_kept_reg;
    assign results.new_label   = out_label_reg;
    assign results.last_result = out_last_reg;

endmodule
